@@ design/dmc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types and constants of the direct-mapped cache tag lookup.
// ----------------------------------------------------------------------------
package dmc_pkg;

  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgW      = 4;
  localparam int unsigned FieldW    = 8;
  localparam int unsigned TagW      = 32;
  localparam int unsigned CntW      = 32;

  localparam logic [CfgIdxW-1:0] CFG_OFFSET_WIDTH = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_INDEX_WIDTH  = 1'b1;

  localparam logic [CfgW-1:0] FieldMaxBits   = 4'd8;
  localparam logic [CfgW-1:0] OffsetWidthRst = 4'd4;
  localparam logic [CfgW-1:0] IndexWidthRst  = 4'd8;
  localparam logic [CntW-1:0] CntMax         = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [CfgW-1:0] ow;
    logic [CfgW-1:0] iw;
  } widths_t;

  typedef struct packed {
    logic [FieldW-1:0] off;
    logic [FieldW-1:0] idx;
    logic [TagW-1:0]   tag;
  } fields_t;

endpackage

@@ design/direct_mapped_cache_hit_miss_model_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_cache_hit_miss_model_top
// Direct-mapped cache tag lookup with saturating hit and miss counters.
//
//   channel   ports                                   handshake
//   access    access_address_i                        start && !busy
//   result    was_hit_o line_index_o block_offset_o   done_o, one cycle
//             address_tag_o hit_total_o miss_total_o
//   config    cfg_idx_i cfg_wdata_i                   cfg_we_i
//
// An item's tag memory read is made in the accept cycle, then compare, and
// write-back on a miss, in the lookup state; the result strobe follows and a
// new item may be taken in that same cycle. No item is taken while busy.
// Reset clears valid bits and counters and loads the reset widths at once; no clearing pass.
// The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module direct_mapped_cache_hit_miss_model_top #(
  parameter int unsigned LINE_COUNT    = 256,
  parameter int unsigned ADDRESS_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [ADDRESS_WIDTH-1:0]        access_address_i,
  output logic                            done_o,
  output logic                            was_hit_o,
  output logic [dmc_pkg::FieldW-1:0]      line_index_o,
  output logic [dmc_pkg::FieldW-1:0]      block_offset_o,
  output logic [dmc_pkg::TagW-1:0]        address_tag_o,
  output logic [dmc_pkg::CntW-1:0]        hit_total_o,
  output logic [dmc_pkg::CntW-1:0]        miss_total_o,
  input  logic                            cfg_we_i,
  input  logic [dmc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [dmc_pkg::CfgW-1:0]        cfg_wdata_i
);

  localparam int unsigned Log2Lines = $clog2(LINE_COUNT + 1) - 1;
  localparam int unsigned IdxW      = (Log2Lines > dmc_pkg::FieldW) ? dmc_pkg::FieldW
                                                                    : Log2Lines;
  localparam int unsigned Depth     = 2 ** IdxW;

  localparam logic StIdle   = 1'b0;
  localparam logic StLookup = 1'b1;

  logic                       state_q, state_d;
  dmc_pkg::widths_t           widths_q;
  dmc_pkg::fields_t           fields_d;
  dmc_pkg::fields_t           fields_q;
  logic [dmc_pkg::TagW-1:0]   tag_mem [Depth];
  logic [dmc_pkg::TagW-1:0]   rd_tag_q;
  logic [Depth-1:0]           valid_q;
  logic [dmc_pkg::CntW-1:0]   hit_cnt_q, hit_cnt_d;
  logic [dmc_pkg::CntW-1:0]   miss_cnt_q, miss_cnt_d;
  logic                       done_q;
  logic                       was_hit_q;
  logic [dmc_pkg::FieldW-1:0] line_index_q;
  logic [dmc_pkg::FieldW-1:0] block_offset_q;
  logic [dmc_pkg::TagW-1:0]   address_tag_q;
  logic                       accept;
  logic                       hit;
  logic                       mem_we;
  logic [IdxW-1:0]            rd_idx;
  logic [IdxW-1:0]            wr_idx;

  dmc_addr_split #(
    .ADDRESS_WIDTH (ADDRESS_WIDTH),
    .IDX_CAP       (IdxW)
  ) u_split (
    .addr_i   (access_address_i),
    .widths_i (widths_q),
    .fields_o (fields_d)
  );

  assign accept = start && (state_q == StIdle);
  assign busy   = (state_q == StLookup);
  assign rd_idx = fields_d.idx[IdxW-1:0];
  assign wr_idx = fields_q.idx[IdxW-1:0];
  assign hit    = valid_q[wr_idx] && (rd_tag_q == fields_q.tag);
  assign mem_we = (state_q == StLookup) && !hit;

  always_comb begin
    state_d    = state_q;
    hit_cnt_d  = hit_cnt_q;
    miss_cnt_d = miss_cnt_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StLookup;
        end
      end
      StLookup: begin
        state_d = StIdle;
        if (hit) begin
          if (hit_cnt_q != dmc_pkg::CntMax) begin
            hit_cnt_d = hit_cnt_q + dmc_pkg::CntW'(1);
          end
        end else begin
          if (miss_cnt_q != dmc_pkg::CntMax) begin
            miss_cnt_d = miss_cnt_q + dmc_pkg::CntW'(1);
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tag_mem[wr_idx] <= fields_q.tag;
    end
    if (accept) begin
      rd_tag_q <= tag_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fields_q <= fields_d;
    end
    if (state_q == StLookup) begin
      was_hit_q      <= hit;
      line_index_q   <= fields_q.idx;
      block_offset_q <= fields_q.off;
      address_tag_q  <= fields_q.tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      done_q      <= 1'b0;
      valid_q     <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      widths_q.ow <= dmc_pkg::OffsetWidthRst;
      widths_q.iw <= dmc_pkg::IndexWidthRst;
    end else begin
      state_q    <= state_d;
      done_q     <= (state_q == StLookup);
      hit_cnt_q  <= hit_cnt_d;
      miss_cnt_q <= miss_cnt_d;
      if (mem_we) begin
        valid_q[wr_idx] <= 1'b1;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          dmc_pkg::CFG_OFFSET_WIDTH: widths_q.ow <= cfg_wdata_i;
          dmc_pkg::CFG_INDEX_WIDTH:  widths_q.iw <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  assign done_o         = done_q;
  assign was_hit_o      = was_hit_q;
  assign line_index_o   = line_index_q;
  assign block_offset_o = block_offset_q;
  assign address_tag_o  = address_tag_q;
  assign hit_total_o    = hit_cnt_q;
  assign miss_total_o   = miss_cnt_q;

endmodule

@@ design/dmc_addr_split.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_addr_split
// Splits an address into block offset, line index and tag after clamping
// the configured field widths.
// ----------------------------------------------------------------------------
module dmc_addr_split #(
  parameter int unsigned ADDRESS_WIDTH = 32,
  parameter int unsigned IDX_CAP       = 8
) (
  input  logic [ADDRESS_WIDTH-1:0] addr_i,
  input  dmc_pkg::widths_t         widths_i,
  output dmc_pkg::fields_t         fields_o
);

  localparam int unsigned ExtW = (ADDRESS_WIDTH > dmc_pkg::TagW) ? ADDRESS_WIDTH
                                                                 : dmc_pkg::TagW;

  logic [dmc_pkg::CfgW-1:0]   ow_c;
  logic [dmc_pkg::CfgW-1:0]   iw_c;
  logic [dmc_pkg::CfgW-1:0]   iw_min;
  logic [ExtW-1:0]            addr_ext;
  logic [ExtW-1:0]            idx_sh;
  logic [ExtW-1:0]            tag_sh;
  logic [dmc_pkg::FieldW-1:0] off_mask;
  logic [dmc_pkg::FieldW-1:0] idx_mask;

  always_comb begin
    ow_c     = (widths_i.ow > dmc_pkg::FieldMaxBits) ? dmc_pkg::FieldMaxBits : widths_i.ow;
    iw_min   = (widths_i.iw == '0) ? dmc_pkg::CfgW'(1) : widths_i.iw;
    iw_c     = (iw_min > dmc_pkg::CfgW'(IDX_CAP)) ? dmc_pkg::CfgW'(IDX_CAP) : iw_min;
    addr_ext = ExtW'(addr_i);
    off_mask = dmc_pkg::FieldW'((9'd1 << ow_c) - 9'd1);
    idx_mask = dmc_pkg::FieldW'((9'd1 << iw_c) - 9'd1);
    idx_sh   = addr_ext >> ow_c;
    tag_sh   = addr_ext >> ({1'b0, ow_c} + {1'b0, iw_c});
    fields_o.off = addr_ext[dmc_pkg::FieldW-1:0] & off_mask;
    fields_o.idx = idx_sh[dmc_pkg::FieldW-1:0] & idx_mask;
    fields_o.tag = tag_sh[dmc_pkg::TagW-1:0];
  end

endmodule

@@ design/dmc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_checker
// Port-level checks of the cache lookup sequencing and counters.
// ----------------------------------------------------------------------------
module dmc_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start_i,
  input logic                     busy_i,
  input logic                     done_i,
  input logic                     was_hit_i,
  input logic [dmc_pkg::CntW-1:0] hit_total_i,
  input logic [dmc_pkg::CntW-1:0] miss_total_i
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i |=> busy_i)
    else $error("accepted item did not enter lookup");

  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_i |=> done_i && !busy_i)
    else $error("lookup did not produce a result");

  a_miss_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && !was_hit_i |->
      (miss_total_i == $past(miss_total_i) + dmc_pkg::CntW'(1)) ||
      (miss_total_i == dmc_pkg::CntMax))
    else $error("miss count not advanced on a miss");

  a_hit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && was_hit_i |->
      $stable(miss_total_i) &&
      ((hit_total_i == $past(hit_total_i) + dmc_pkg::CntW'(1)) ||
       (hit_total_i == dmc_pkg::CntMax)))
    else $error("counters wrong on a hit");

endmodule

bind direct_mapped_cache_hit_miss_model_top dmc_checker u_dmc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start),
  .busy_i       (busy),
  .done_i       (done_o),
  .was_hit_i    (was_hit_o),
  .hit_total_i  (hit_total_o),
  .miss_total_i (miss_total_o)
);
